FILE: design/fatdt_pkg.sv
// ----------------------------------------------------------------------------
// FAT timestamp conversion package
// Shared widths, constants, lookup tables and the decode record that passes
// from the field decoder to the multiply pipeline.
// ----------------------------------------------------------------------------
package fatdt_pkg;

  localparam int DaysW  = 18;  // day number since the epoch, up to about 185k
  localparam int TodW   = 17;  // seconds within a day, up to 86399
  localparam int RemW   = 7;   // hundredths left over after whole seconds
  localparam int SecW   = 35;  // total seconds since the epoch
  localparam int LoW    = 17;  // low part of the seconds split for the multiply
  localparam int HiW    = SecW - LoW;
  localparam int TickW  = 58;

  // Days from 1601-01-01 to 1980-01-01.
  localparam logic [DaysW-1:0] BaseDays = 18'd138426;
  localparam logic [16:0] SecPerDay = 17'd86400;
  localparam logic [23:0] TkPerSec  = 24'd10000000;
  // Ticks in one hundredth of a second.
  localparam logic [16:0] TkPerHun  = 17'd100000;
  localparam logic [6:0]  YearOf2100 = 7'd120;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonDec = 4'd12;

  typedef struct packed {
    logic             ok;
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
    logic [RemW-1:0]  rem;
  } dec_t;

  // Days in the year before the first of the given month.
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of the month in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] n;
    case (mon)
      4'd2:    n = 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

FILE: design/fatdt_decode.sv
// ----------------------------------------------------------------------------
// FAT timestamp field decoder
// Checks the date and time fields, forms the day number since the epoch and
// the second of the day, and registers them as the first pipeline stage.
// ----------------------------------------------------------------------------
module fatdt_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [6:0]          year_offset,
  input  logic [3:0]          month,
  input  logic [4:0]          day,
  input  logic [4:0]          hour,
  input  logic [5:0]          minute,
  input  logic [4:0]          double_seconds,
  input  logic [7:0]          hundredths,
  output logic                out_vld,
  output fatdt_pkg::dec_t     out_dec
);

  logic            leap;
  logic [1:0]      hsec;
  logic [6:0]      sec_raw;
  logic [5:0]      sec;
  logic [5:0]      mlen;
  logic [7:0]      yo_p3;
  logic [5:0]      leap_cnt;
  logic [17:0]     days_acc;
  logic [16:0]     tod_acc;
  fatdt_pkg::dec_t dec_next;

  always_comb begin
    // Inside 1980..2107 the only century year that is not leap is 2100.
    leap = (year_offset[1:0] == 2'd0) && (year_offset != fatdt_pkg::YearOf2100);

    if (hundredths >= 8'd200) begin
      hsec = 2'd2;
    end else if (hundredths >= 8'd100) begin
      hsec = 2'd1;
    end else begin
      hsec = 2'd0;
    end
    dec_next.rem = 7'(hundredths - 8'(hsec) * 8'd100);

    sec_raw = {1'b0, double_seconds, 1'b0} + 7'(hsec);
    sec     = (sec_raw > 7'd59) ? 6'd0 : sec_raw[5:0];

    mlen = {1'b0, fatdt_pkg::month_len(month)}
         + ((leap && month == fatdt_pkg::MonFeb) ? 6'd1 : 6'd0);

    dec_next.ok = (month >= fatdt_pkg::MonJan) && (month <= fatdt_pkg::MonDec)
               && (hour <= 5'd23) && (minute <= 6'd59)
               && (day != 5'd0) && ({1'b0, day} <= mlen);

    // Leap years in [1980, year-1], less one once 2100 has gone by.
    yo_p3    = {1'b0, year_offset} + 8'd3;
    leap_cnt = yo_p3[7:2] - ((year_offset > fatdt_pkg::YearOf2100) ? 6'd1 : 6'd0);

    days_acc = fatdt_pkg::BaseDays + 18'(year_offset) * 18'd365 + 18'(leap_cnt)
             + 18'(fatdt_pkg::cum_days(month))
             + ((leap && month > fatdt_pkg::MonFeb) ? 18'd1 : 18'd0)
             + 18'(day) - 18'd1;
    dec_next.days = days_acc;

    tod_acc = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(sec);
    dec_next.tod = tod_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_dec <= dec_next;
  end

endmodule

FILE: design/fatdt_mul.sv
// ----------------------------------------------------------------------------
// FAT timestamp tick multiplier
// Scales the day number to seconds, adds the time of day, splits the seconds
// into high and low parts for the tick multiply and sums the partial products.
// ----------------------------------------------------------------------------
module fatdt_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  fatdt_pkg::dec_t in_dec,
  output logic            out_vld,
  output logic [57:0]     tick_count,
  output logic            valid_res
);

  // Stage A: day number times seconds per day.
  logic        a_vld;
  logic        a_ok;
  logic [33:0] a_daysec;
  logic [16:0] a_tod;
  logic [6:0]  a_rem;

  // Stage B: total seconds and the sub-second ticks.
  logic        b_vld;
  logic        b_ok;
  logic [34:0] b_sec;
  logic [23:0] b_frac;

  // Stage C: partial products of the seconds times ticks per second.
  logic        c_vld;
  logic        c_ok;
  logic [41:0] c_hi;
  logic [40:0] c_lo;
  logic [23:0] c_frac;

  logic [57:0] tick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      c_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      a_vld   <= in_vld;
      b_vld   <= a_vld;
      c_vld   <= b_vld;
      out_vld <= c_vld;
    end
  end

  always_comb begin
    tick_next = ({16'd0, c_hi} << fatdt_pkg::LoW) + {17'd0, c_lo} + {34'd0, c_frac};
  end

  always_ff @(posedge clk) begin
    a_ok     <= in_dec.ok;
    a_daysec <= 34'(in_dec.days) * 34'(fatdt_pkg::SecPerDay);
    a_tod    <= in_dec.tod;
    a_rem    <= in_dec.rem;

    b_ok     <= a_ok;
    b_sec    <= {1'b0, a_daysec} + 35'(a_tod);
    b_frac   <= 24'(a_rem) * 24'(fatdt_pkg::TkPerHun);

    c_ok     <= b_ok;
    c_hi     <= 42'(b_sec[34:fatdt_pkg::LoW]) * 42'(fatdt_pkg::TkPerSec);
    c_lo     <= 41'(b_sec[fatdt_pkg::LoW-1:0]) * 41'(fatdt_pkg::TkPerSec);
    c_frac   <= b_frac;

    valid_res  <= c_ok;
    tick_count <= c_ok ? tick_next : 58'd0;
  end

endmodule

FILE: design/fat_datetime_to_tick_count.sv
// ----------------------------------------------------------------------------
// FAT timestamp to 100 ns tick count
// Converts one FAT directory timestamp into ticks since 1601-01-01 with a
// flag that reports whether the date and time fields were in range.
// ----------------------------------------------------------------------------
// A request taken at a clock edge has its result marked by done for a
// single cycle once it has passed through all five register stages.
// Throughput: one request per cycle; busy stays low, and the five register
// stages (decode, day scaling, seconds sum, split multiply, final sum) run
// in lock step. Reset empties the pipeline; results cannot be held off.
module fat_datetime_to_tick_count (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  year_offset,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [4:0]  double_seconds,
  input  logic [7:0]  hundredths,
  output logic        done,
  output logic [57:0] tick_count,
  output logic        valid_res
);

  logic            dec_vld;
  fatdt_pkg::dec_t dec;

  assign busy = 1'b0;

  fatdt_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .in_vld         (start),
    .year_offset    (year_offset),
    .month          (month),
    .day            (day),
    .hour           (hour),
    .minute         (minute),
    .double_seconds (double_seconds),
    .hundredths     (hundredths),
    .out_vld        (dec_vld),
    .out_dec        (dec)
  );

  fatdt_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (dec_vld),
    .in_dec     (dec),
    .out_vld    (done),
    .tick_count (tick_count),
    .valid_res  (valid_res)
  );

  a_req_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("request did not produce a result five cycles later");

  a_result_had_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result appeared without a matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !valid_res |-> tick_count == 58'd0)
    else $error("rejected timestamp carries a nonzero tick count");

endmodule

FILE: test/tb_fat_datetime_to_tick_count.sv
// ----------------------------------------------------------------------------
// FAT timestamp to tick count testbench
// Sends FAT date and time stamps to the converter and checks every tick count
// and valid flag against a predictor of the Gregorian calendar arithmetic.
// Directed stamps cover field extremes, leap days and seconds wrap, and random
// stamps follow; idle gaps on the request side are off for one stretch of them.
// ----------------------------------------------------------------------------
module tb_fat_datetime_to_tick_count;

  localparam int CycleLimit = 200000;
  localparam int unsigned FatBaseYear = 1980;
  localparam int unsigned EpochYear = 1601;
  localparam int unsigned LastHour = 23;
  localparam int unsigned LastMinute = 59;
  localparam int unsigned LastSecond = 59;
  localparam longint unsigned DaysPerYear = 365;
  localparam longint unsigned SecsPerDay = 86400;
  localparam longint unsigned TicksPerSec = 10000000;
  localparam longint unsigned TicksPerMs = 10000;

  typedef struct packed {
    logic [6:0] year_offset;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] double_seconds;
    logic [7:0] hundredths;
  } fat_stamp_t;

  typedef struct packed {
    logic [fatdt_pkg::TickW-1:0] ticks;
    logic                        ok;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [6:0] year_offset;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [4:0] double_seconds;
  logic [7:0] hundredths;
  logic done;
  logic [57:0] tick_count;
  logic valid_res;

  int unsigned days_before_month [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int unsigned days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  tick_result_t pending_ticks_q[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit idling_on;

  fat_datetime_to_tick_count DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .year_offset(year_offset),
    .month(month),
    .day(day),
    .hour(hour),
    .minute(minute),
    .double_seconds(double_seconds),
    .hundredths(hundredths),
    .done(done),
    .tick_count(tick_count),
    .valid_res(valid_res)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_ticks_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input logic [3:0] mon, input int unsigned yr);
    return days_in_month[int'(mon) - 1]
           + ((mon == fatdt_pkg::MonFeb && is_leap_year(yr)) ? 1 : 0);
  endfunction

  function automatic tick_result_t fat_stamp_ticks(input fat_stamp_t s);
    tick_result_t r;
    int unsigned yr;
    int unsigned secs;
    int unsigned msecs;
    longint unsigned prior;
    longint unsigned epoch;
    longint unsigned days;
    longint unsigned total;
    yr = FatBaseYear + int'(s.year_offset);
    secs = 2 * int'(s.double_seconds) + int'(s.hundredths) / 100;
    if (secs > LastSecond) secs = 0;
    msecs = (int'(s.hundredths) % 100) * 10;
    r.ok = (s.month >= fatdt_pkg::MonJan) && (s.month <= fatdt_pkg::MonDec)
           && (s.hour <= LastHour) && (s.minute <= LastMinute) && (s.day >= 1);
    if (r.ok && s.day > month_length(s.month, yr)) r.ok = 1'b0;
    r.ticks = '0;
    if (r.ok) begin
      prior = longint'(yr) - 1;
      epoch = longint'(EpochYear) - 1;
      days = (prior * DaysPerYear + prior / 4 - prior / 100 + prior / 400)
             - (epoch * DaysPerYear + epoch / 4 - epoch / 100 + epoch / 400)
             + days_before_month[int'(s.month) - 1]
             + ((is_leap_year(yr) && s.month > fatdt_pkg::MonFeb) ? 1 : 0)
             + longint'(s.day) - 1;
      total = (days * SecsPerDay + longint'(s.hour) * 3600 + longint'(s.minute) * 60
               + longint'(secs)) * TicksPerSec + longint'(msecs) * TicksPerMs;
      r.ticks = total[fatdt_pkg::TickW-1:0];
    end
    return r;
  endfunction

  function automatic fat_stamp_t make_stamp(input int y, input int mo, input int d, input int h,
                                            input int mi, input int ds, input int hu);
    fat_stamp_t s;
    s.year_offset = 7'(y);
    s.month = 4'(mo);
    s.day = 5'(d);
    s.hour = 5'(h);
    s.minute = 6'(mi);
    s.double_seconds = 5'(ds);
    s.hundredths = 8'(hu);
    return s;
  endfunction

  // Idle cycles put random noise on the fields with start low.
  task automatic send_request(input fat_stamp_t s);
    logic [63:0] noise;
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 33) begin
      noise = {$urandom(), $urandom()};
      start <= 1'b0;
      {year_offset, month, day, hour, minute, double_seconds, hundredths} <=
          noise[$bits(fat_stamp_t)-1:0];
      @(negedge clk);
    end
    start <= 1'b1;
    {year_offset, month, day, hour, minute, double_seconds, hundredths} <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_ticks_q.push_back(fat_stamp_ticks(s));
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && done) begin
      if (pending_ticks_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tick_count %0d valid_res %0b",
                 $time, tick_count, valid_res);
        mismatches++;
      end else begin
        want = pending_ticks_q.pop_front();
        if (tick_count !== want.ticks) begin
          $display("%0t: tick_count mismatch, expected %0d, actual %0d",
                   $time, want.ticks, tick_count);
          mismatches++;
        end
        if (valid_res !== want.ok) begin
          $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                   $time, want.ok, valid_res);
          mismatches++;
        end
      end
    end
  end

  task automatic test_field_extremes();
    send_request(make_stamp(0, 1, 1, 0, 0, 0, 0));
    send_request(make_stamp(127, 12, 31, 23, 59, 29, 99));
    send_request(make_stamp(127, 15, 31, 31, 63, 31, 255));
    send_request(make_stamp(0, 0, 0, 0, 0, 0, 0));
    send_request(make_stamp(10, 13, 1, 0, 0, 0, 0));
    send_request(make_stamp(10, 6, 0, 12, 0, 0, 0));
    send_request(make_stamp(10, 6, 15, 24, 0, 0, 0));
    send_request(make_stamp(10, 6, 15, 23, 60, 0, 0));
    send_request(make_stamp(10, 4, 31, 0, 0, 0, 0));
    send_request(make_stamp(10, 4, 30, 0, 0, 0, 0));
  endtask

  // The year 2100 is a century year that is not a leap year.
  task automatic test_leap_days();
    send_request(make_stamp(0, 2, 29, 1, 2, 3, 4));
    send_request(make_stamp(20, 2, 29, 12, 30, 15, 50));
    send_request(make_stamp(120, 2, 29, 0, 0, 0, 0));
    send_request(make_stamp(21, 2, 29, 0, 0, 0, 0));
    send_request(make_stamp(120, 3, 1, 0, 0, 0, 0));
    send_request(make_stamp(20, 12, 31, 23, 59, 29, 0));
  endtask

  // Whole seconds from the hundredths can push the count past 59, which wraps to zero.
  task automatic test_second_wrap();
    send_request(make_stamp(45, 7, 14, 8, 20, 29, 99));
    send_request(make_stamp(45, 7, 14, 8, 20, 29, 100));
    send_request(make_stamp(45, 7, 14, 8, 20, 29, 200));
    send_request(make_stamp(45, 7, 14, 8, 20, 30, 0));
    send_request(make_stamp(45, 7, 14, 8, 20, 31, 255));
    send_request(make_stamp(45, 7, 14, 8, 20, 0, 255));
    send_request(make_stamp(45, 7, 14, 8, 20, 15, 100));
  endtask

  // Most stamps are well formed with random content; the rest are raw field noise.
  task automatic test_random_stamps(input int count);
    fat_stamp_t s;
    logic [63:0] raw;
    int unsigned len;
    for (int i = 0; i < count; i++) begin
      idling_on = !(i >= 400 && i < 700);
      if ($urandom_range(99) < 70) begin
        s.year_offset = 7'($urandom_range(127));
        s.month = 4'($urandom_range(12, 1));
        len = month_length(s.month, FatBaseYear + int'(s.year_offset));
        s.day = ($urandom_range(4) == 0) ? 5'(len) : 5'($urandom_range(len, 1));
        s.hour = 5'($urandom_range(LastHour));
        s.minute = 6'($urandom_range(LastMinute));
        s.double_seconds = 5'($urandom_range(31));
        s.hundredths = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
      end else begin
        raw = {$urandom(), $urandom()};
        s = raw[$bits(fat_stamp_t)-1:0];
      end
      send_request(s);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    {year_offset, month, day, hour, minute, double_seconds, hundredths} = '0;
    idling_on = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_leap_days();
    test_second_wrap();
    test_random_stamps(1200);
    @(negedge clk);
    start <= 1'b0;
    while (pending_ticks_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/fatdt_pkg.sv
design/fatdt_decode.sv
design/fatdt_mul.sv
design/fat_datetime_to_tick_count.sv
test/tb_fat_datetime_to_tick_count.sv
